>>> design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Types, constants and scanner tables shared by the token scanner modules.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int MAX_TOKEN   = 64;
    localparam int PTR_W       = $clog2(MAX_TOKEN);
    localparam int FILL_W      = PTR_W + 1;
    localparam int MAX_RESULTS = 64;
    localparam int CHAIN_MAX   = 8;

    localparam logic [6:0] JAM_BASE       = 7'd70;
    localparam logic [5:0] JAM_STATE      = 6'd44;
    localparam logic [5:0] FIRST_TEMPLATE = 6'd45;
    localparam logic [5:0] NSTATES        = 6'd47;
    localparam logic [7:0] NSLOTS         = 8'd97;
    localparam logic [3:0] NO_ACTION      = 4'd0;
    localparam logic [3:0] EOF_ACTION     = 4'd11;

    typedef struct packed {
        logic [4:0] cls;
        logic       eoi;
    } t_qitem;

    typedef struct packed {
        logic [3:0] action;
        logic [6:0] token_length;
        logic       overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE, S_ITEM, S_WALK, S_CUT, S_READ, S_LOAD, S_FLUSH, S_DONE
    } t_bstate;

    localparam logic [4:0] LETTER_CLASS [0:28] = '{
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd10,
        5'd10, 5'd10, 5'd10, 5'd19, 5'd20, 5'd21, 5'd10, 5'd22, 5'd10, 5'd23,
        5'd24, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd25, 5'd1, 5'd26
    };

    localparam logic [4:0] PUNCT_CLASS [0:5] = '{5'd4, 5'd5, 5'd1, 5'd6, 5'd7, 5'd8};

    localparam logic [1:0] META_OF [0:26] = '{
        2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
        2'd3, 2'd2, 2'd1
    };

    localparam logic [3:0] ACTION_OF [0:44] = '{
        4'd0, 4'd0, 4'd0, 4'd10, 4'd8, 4'd7, 4'd7, 4'd5, 4'd1, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd7, 4'd2, 4'd1, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd3, 4'd4, 4'd4, 4'd0, 4'd6, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd0
    };

    localparam logic [6:0] BASE_OF [0:46] = '{
        7'd0, 7'd0, 7'd0, 7'd69, 7'd70, 7'd25, 7'd27, 7'd70, 7'd24, 7'd0, 7'd54,
        7'd48, 7'd42, 7'd50, 7'd42, 7'd46, 7'd36, 7'd32, 7'd52, 7'd29, 7'd0,
        7'd44, 7'd46, 7'd39, 7'd0, 7'd37, 7'd42, 7'd29, 7'd70, 7'd45, 7'd35,
        7'd40, 7'd39, 7'd31, 7'd30, 7'd25, 7'd33, 7'd28, 7'd32, 7'd24, 7'd19,
        7'd23, 7'd18, 7'd23, 7'd70, 7'd29, 7'd38
    };

    localparam logic [5:0] DEFAULT_OF [0:46] = '{
        6'd0, 6'd44, 6'd1, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd45, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46, 6'd44, 6'd44, 6'd44, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46, 6'd44, 6'd44, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd0, 6'd44, 6'd44
    };

    localparam logic [5:0] NEXT_OF [0:96] = '{
        6'd0, 6'd4, 6'd5, 6'd6, 6'd7, 6'd7, 6'd7, 6'd4, 6'd7, 6'd8, 6'd9, 6'd10,
        6'd9, 6'd9, 6'd11, 6'd12, 6'd9, 6'd9, 6'd13, 6'd9, 6'd9, 6'd14, 6'd9,
        6'd15, 6'd9, 6'd16, 6'd4, 6'd17, 6'd17, 6'd17, 6'd17, 6'd18, 6'd20,
        6'd19, 6'd17, 6'd17, 6'd18, 6'd24, 6'd19, 6'd27, 6'd43, 6'd27, 6'd24,
        6'd42, 6'd41, 6'd40, 6'd39, 6'd38, 6'd37, 6'd24, 6'd24, 6'd36, 6'd35,
        6'd34, 6'd29, 6'd28, 6'd33, 6'd32, 6'd31, 6'd24, 6'd30, 6'd29, 6'd28,
        6'd26, 6'd25, 6'd24, 6'd23, 6'd22, 6'd21, 6'd44, 6'd3, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44
    };

    localparam logic [5:0] OWNER_OF [0:96] = '{
        6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
        6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1,
        6'd1, 6'd1, 6'd1, 6'd5, 6'd5, 6'd6, 6'd6, 6'd8, 6'd45, 6'd8, 6'd17,
        6'd17, 6'd19, 6'd43, 6'd19, 6'd46, 6'd42, 6'd46, 6'd41, 6'd40, 6'd39,
        6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd29,
        6'd27, 6'd26, 6'd25, 6'd23, 6'd22, 6'd21, 6'd18, 6'd16, 6'd15, 6'd14,
        6'd13, 6'd12, 6'd11, 6'd10, 6'd3, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44
    };

    function automatic logic [4:0] byte_class(input logic [7:0] b);
        logic [4:0] c;
        c = 5'd1;
        if (b == 8'd0) begin
            c = 5'd0;
        end else if (b == 8'd9 || b == 8'd32) begin
            c = 5'd2;
        end else if (b == 8'd10) begin
            c = 5'd3;
        end else if (b >= 8'd42 && b <= 8'd47) begin
            c = PUNCT_CLASS[3'(b - 8'd42)];
        end else if (b >= 8'd48 && b <= 8'd57) begin
            c = 5'd9;
        end else if (b >= 8'd97 && b <= 8'd125) begin
            c = LETTER_CLASS[5'(b - 8'd97)];
        end
        return c;
    endfunction

    function automatic logic [3:0] action_of(input logic [5:0] s);
        return (s < FIRST_TEMPLATE) ? ACTION_OF[s] : NO_ACTION;
    endfunction

    function automatic logic [6:0] base_of(input logic [5:0] s);
        return (s < NSTATES) ? BASE_OF[s] : 7'd0;
    endfunction

endpackage

>>> design/dts_in_if.sv
// ----------------------------------------------------------------------------
// dts_in_if
// Input channel of the token scanner: one raw byte or an end mark per item.
// ----------------------------------------------------------------------------
interface dts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

>>> design/dts_out_if.sv
// ----------------------------------------------------------------------------
// dts_out_if
// Result channel of the token scanner: one reported token per item.
// ----------------------------------------------------------------------------
interface dts_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic [6:0] token_length;
    logic       overflow;
    logic       last;

    modport source (output valid, output action, output token_length, output overflow,
                    output last, input ready);
    modport sink   (input valid, input action, input token_length, input overflow,
                    input last, output ready);
endinterface

>>> design/dts_front.sv
// ----------------------------------------------------------------------------
// dts_front
// Accepts input items, maps each byte to its class and holds them in a
// two-entry queue for the scanning engine.
// ----------------------------------------------------------------------------
module dts_front
    import dts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dts_in_if.sink i_in,
    output logic   o_q_valid,
    output t_qitem o_q_item,
    input  logic   i_q_ready
);

    t_qitem     r_buf [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_buf[r_rp];
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= '{cls: byte_class(i_in.byte_in), eoi: i_in.end_of_input};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> design/dts_back.sv
// ----------------------------------------------------------------------------
// dts_back
// Scanning engine: walks the compressed tables one chain step per cycle,
// buffers token classes in a ring memory, resolves longest matches, rescans
// read-ahead bytes and delivers results through an output register.
// ----------------------------------------------------------------------------
module dts_back
    import dts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_q_valid,
    input  t_qitem     i_q_item,
    output logic       o_q_ready,
    dts_out_if.source  o_out
);

    t_bstate           r_state, n_state;
    logic [1:0]        r_start;
    logic [5:0]        r_dfa, n_dfa;
    logic [5:0]        r_acc, n_acc;
    logic [FILL_W-1:0] r_acclen, n_acclen;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0] r_pos, n_pos;
    logic [5:0]        r_ws, n_ws;
    logic [4:0]        r_wc, n_wc;
    logic [2:0]        r_guard, n_guard;
    logic              r_flush, n_flush;
    logic [4:0]        r_icls, n_icls;
    logic              r_ieoi, n_ieoi;
    logic [6:0]        r_nres, n_nres;
    logic              r_pend_v, n_pend_v;
    t_result           r_pend, n_pend;
    logic              r_ovalid;
    t_result           r_out;
    logic              r_olast;
    logic [4:0]        r_mem [0:MAX_TOKEN-1];
    logic [4:0]        r_rdata;

    logic [5:0]        entry;
    logic              out_free;
    logic              put_req;
    t_result           put_res;
    logic              fin_req;
    logic              stall;
    logic              push;
    logic              push_last;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [PTR_W-1:0]  mem_raddr;
    logic [7:0]        w_slot;
    logic              w_hit;
    logic              w_done;
    logic [5:0]        w_res;
    logic [5:0]        w_ns;
    logic [4:0]        w_nc;
    logic              w_jam;
    logic [3:0]        c_act;
    logic [FILL_W-1:0] c_len;
    logic [3:0]        o_act;
    logic [4:0]        feed_cls;

    assign entry     = (r_start == 2'd2) ? 6'd2 : 6'd1;
    assign out_free  = !r_ovalid || o_out.ready;
    assign o_q_ready = (r_state == S_IDLE);
    assign mem_waddr = r_head + r_fill[PTR_W-1:0];
    assign mem_raddr = r_head + r_pos[PTR_W-1:0];
    assign mem_we    = (r_state == S_ITEM) && !r_ieoi && (r_fill < FILL_W'(MAX_TOKEN));
    assign feed_cls  = (r_state == S_ITEM) ? r_icls : r_rdata;

    always_comb begin
        w_slot = {1'b0, base_of(r_ws)} + {3'b000, r_wc};
        w_hit  = (r_ws < NSTATES) && (w_slot < NSLOTS) && (OWNER_OF[w_slot[6:0]] == r_ws);
        w_ns   = (r_ws < NSTATES) ? DEFAULT_OF[r_ws] : JAM_STATE;
        w_nc   = (w_ns >= FIRST_TEMPLATE) ? {3'b000, META_OF[r_wc]} : r_wc;
        w_done = 1'b1;
        w_res  = JAM_STATE;
        if (r_ws >= NSTATES) begin
            w_res = JAM_STATE;
        end else if (w_hit) begin
            w_res = NEXT_OF[w_slot[6:0]];
        end else if (r_guard != 3'(CHAIN_MAX - 1)) begin
            w_done = 1'b0;
        end
        w_jam = (base_of(w_res) == JAM_BASE);
    end

    always_comb begin
        c_act = action_of(r_dfa);
        c_len = r_pos;
        if (c_act == NO_ACTION) begin
            c_act = action_of(r_acc);
            c_len = r_acclen;
        end
        if (c_len == '0 || c_len > r_pos || c_len > r_fill) begin
            c_act = NO_ACTION;
            c_len = FILL_W'(1);
        end
        if (c_len > r_fill) begin
            c_len = r_fill;
        end
        o_act = (action_of(r_dfa) != NO_ACTION) ? action_of(r_dfa) : action_of(r_acc);
    end

    always_comb begin
        put_req = 1'b0;
        put_res = '{action: NO_ACTION, token_length: 7'd0, overflow: 1'b0};
        fin_req = 1'b0;
        unique case (r_state)
            S_ITEM: begin
                if (!r_ieoi && r_fill >= FILL_W'(MAX_TOKEN)) begin
                    put_req = 1'b1;
                    put_res = '{action: o_act, token_length: 7'(r_fill), overflow: 1'b1};
                end
            end
            S_CUT: begin
                put_req = 1'b1;
                put_res = '{action: c_act, token_length: 7'(c_len), overflow: 1'b0};
            end
            S_FLUSH: begin
                if (r_fill == '0) begin
                    put_req = 1'b1;
                    put_res = '{action: EOF_ACTION, token_length: 7'd0, overflow: 1'b0};
                end
            end
            S_DONE:  fin_req = r_pend_v;
            default: ;
        endcase
        stall     = ((put_req && r_nres < 7'(MAX_RESULTS)) || fin_req) && r_pend_v && !out_free;
        push      = !stall && r_pend_v &&
                    ((put_req && r_nres < 7'(MAX_RESULTS)) || fin_req);
        push_last = fin_req;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_ITEM;
                end
            end
            S_ITEM: begin
                if (r_ieoi) begin
                    n_state = S_FLUSH;
                end else if (r_fill < FILL_W'(MAX_TOKEN)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_done) begin
                    n_state = w_jam ? S_CUT : S_READ;
                end
            end
            S_CUT: begin
                if (!stall) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_pos < r_fill) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = r_flush ? S_FLUSH : S_DONE;
                end
            end
            S_LOAD:  n_state = S_WALK;
            S_FLUSH: begin
                if (r_fill != '0) begin
                    n_state = S_CUT;
                end else if (!stall) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_dfa    = r_dfa;
        n_acc    = r_acc;
        n_acclen = r_acclen;
        n_fill   = r_fill;
        n_head   = r_head;
        n_pos    = r_pos;
        n_ws     = r_ws;
        n_wc     = r_wc;
        n_guard  = r_guard;
        n_flush  = r_flush;
        n_icls   = r_icls;
        n_ieoi   = r_ieoi;
        n_nres   = r_nres;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        unique case (r_state)
            S_IDLE: begin
                n_icls  = i_q_item.cls;
                n_ieoi  = i_q_item.eoi;
                n_nres  = 7'd0;
                n_flush = 1'b0;
            end
            S_ITEM: begin
                if (r_ieoi) begin
                    n_flush = 1'b1;
                end else if (r_fill >= FILL_W'(MAX_TOKEN)) begin
                    if (!stall) begin
                        n_head   = r_head + r_fill[PTR_W-1:0];
                        n_fill   = '0;
                        n_dfa    = entry;
                        n_acc    = 6'd0;
                        n_acclen = '0;
                    end
                end else begin
                    n_fill = r_fill + FILL_W'(1);
                    n_pos  = r_fill;
                end
            end
            S_WALK: begin
                if (w_done) begin
                    n_dfa = w_res;
                    n_pos = r_pos + FILL_W'(1);
                end else begin
                    n_ws    = w_ns;
                    n_wc    = w_nc;
                    n_guard = r_guard + 3'd1;
                end
            end
            S_CUT: begin
                if (!stall) begin
                    n_head   = r_head + c_len[PTR_W-1:0];
                    n_fill   = r_fill - c_len;
                    n_dfa    = entry;
                    n_acc    = 6'd0;
                    n_acclen = '0;
                    n_pos    = '0;
                end
            end
            S_FLUSH: begin
                if (r_fill != '0) begin
                    n_pos = r_fill;
                end else if (!stall) begin
                    n_dfa    = entry;
                    n_acc    = 6'd0;
                    n_acclen = '0;
                end
            end
            S_DONE: begin
                if (!stall) begin
                    n_pend_v = 1'b0;
                end
            end
            default: ;
        endcase
        if ((r_state == S_ITEM && !r_ieoi && r_fill < FILL_W'(MAX_TOKEN)) ||
            r_state == S_LOAD) begin
            if (action_of(r_dfa) != NO_ACTION) begin
                n_acc    = r_dfa;
                n_acclen = (r_state == S_ITEM) ? r_fill : r_pos;
            end
            n_ws    = r_dfa;
            n_wc    = feed_cls;
            n_guard = 3'd0;
        end
        if (put_req && !stall && r_nres < 7'(MAX_RESULTS)) begin
            n_pend   = put_res;
            n_pend_v = 1'b1;
            n_nres   = r_nres + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_icls;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_ws     <= n_ws;
        r_wc     <= n_wc;
        r_guard  <= n_guard;
        r_icls   <= n_icls;
        r_ieoi   <= n_ieoi;
        r_nres   <= n_nres;
        r_pend   <= n_pend;
        r_flush  <= n_flush;
        if (push) begin
            r_out   <= r_pend;
            r_olast <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 2'd1;
            r_dfa    <= 6'd1;
            r_acc    <= 6'd0;
            r_acclen <= '0;
            r_fill   <= '0;
            r_head   <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dfa    <= n_dfa;
            r_acc    <= n_acc;
            r_acclen <= n_acclen;
            r_fill   <= n_fill;
            r_head   <= n_head;
            r_pend_v <= n_pend_v;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.action       = r_out.action;
    assign o_out.token_length = r_out.token_length;
    assign o_out.overflow     = r_out.overflow;
    assign o_out.last         = r_olast;

endmodule

>>> design/dfa_token_scanner.sv
// ----------------------------------------------------------------------------
// dfa_token_scanner
// Longest-match table-driven token scanner with a classifying front end,
// a short queue and a sequenced scanning engine.
// ----------------------------------------------------------------------------
//  Channel   Direction  Item
//  i_in      in         byte_in, end_of_input
//  o_out     out        action, token_length, overflow, last
//  i_cfg_*   in         entry state write
//
// A byte walks one to eight default-chain steps in the single table-walk
// unit. A jam adds a cut and a rescan of each read-ahead byte, read from
// the token ring memory. Reset is synchronous and clears the state, entry
// state, match, ring and valid registers. A stalled result
// output holds the engine only when a further result must be handed over.
module dfa_token_scanner
    import dts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    dts_in_if.sink     i_in,
    dts_out_if.source  o_out
);

    logic   q_valid;
    logic   q_ready;
    t_qitem q_item;

    dts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_ready (q_ready)
    );

    dts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_ready   (q_ready),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.token_length <= 7'(MAX_TOKEN))
        else $error("token length beyond buffer depth");

    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.action <= EOF_ACTION)
        else $error("action code out of range");

    a_eof_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.action == EOF_ACTION) |->
        (o_out.token_length == 7'd0 && !o_out.overflow && o_out.last))
        else $error("malformed end-of-input result");
`endif

endmodule
